FILE: rtl/tccs_pkg.sv
// tccs_pkg: shared constants and types of the text console cursor and scroll unit
// no dependencies; used by the top level and the remainder unit defaults

package tccs_pkg;

  // default screen geometry
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  // character codes with a meaning of their own
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

endpackage

FILE: rtl/tccs_mod_unit.sv
// tccs_mod_unit: remainder of a cursor offset by the tab stop
// reciprocal multiply for the quotient, then multiply back and subtract; needs tccs_pkg

module tccs_mod_unit #(
  parameter int unsigned LIN_W    = 11,
  parameter int unsigned TAB_STOP = tccs_pkg::TAB_STOP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [LIN_W-1:0]                  dividend_i,
  output logic                              done_o,
  output logic [$clog2(TAB_STOP+1)-1:0]     rem_o
);

  localparam int unsigned REM_W = $clog2(TAB_STOP + 1);
  // shift wide enough that the rounded-up reciprocal is exact for every offset
  localparam int unsigned SH    = LIN_W + $clog2(TAB_STOP);
  localparam int unsigned MW    = SH + 1;
  localparam int unsigned PW    = LIN_W + MW;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SH) + 64'(TAB_STOP) - 64'd1) / 64'(TAB_STOP);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_VAL);

  logic             busy_q;
  logic             done_q;
  logic [LIN_W-1:0] dv_q;
  logic [LIN_W-1:0] quo_q;
  logic [REM_W-1:0] rem_q;
  logic [PW-1:0]    prod;
  logic [LIN_W-1:0] back;

  assign prod = PW'(dividend_i) * PW'(RECIP);
  assign back = quo_q * LIN_W'(TAB_STOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dv_q   <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        dv_q   <= dividend_i;
        quo_q  <= prod[SH +: LIN_W];
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        rem_q  <= REM_W'(dv_q - back);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/text_console_cursor_scroll_unit.sv
// text_console_cursor_scroll_unit: character-cell screen store with a cursor,
// put/set/clear/read commands and scroll-up; uses tccs_pkg and tccs_mod_unit
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tuser: cmd; tdata: char, col, row
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata: cursor, cell, scrolled
//   cfg       in         cfg_valid_i/cfg_ready_o       cfg_data_i: text attribute
//
// one command at a time through a small sequencer around a one-read, one-write screen ram
// put writes the cell and steps the cursor; tab gets the remainder from tccs_mod_unit and
// steps to the next stop; clear blanks every cell; a scroll copies every row but the top
// one a row up, one cell read and written back at a time, then blanks the bottom row
// reset homes the cursor and sets the attribute to 7; the screen is unknown until cleared
// the result sits in an output register, so a stalled sink only holds the next result

module text_console_cursor_scroll_unit #(
  parameter int unsigned COLUMNS  = tccs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tccs_pkg::ROWS_DEF,
  parameter int unsigned TAB_STOP = tccs_pkg::TAB_STOP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code, [14:8] col, [19:15] row, [23:20] zero
  input  logic [tccs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] cmd
  input  logic [tccs_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char, [27:20] cell_attr,
  // [28] scrolled, [31:29] zero
  output logic [tccs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [7:0]                        cfg_data_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned TW    = $clog2(TAB_STOP + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TAB_REM,
    S_STEP,
    S_CP_RD,
    S_CP_WR,
    S_FILL,
    S_RD,
    S_RDW,
    S_DONE
  } state_e;

  state_e              state_q;
  tccs_pkg::cmd_e      cmd_q;
  logic [7:0]          char_q;
  logic [RW-1:0]       arg_row_q;
  logic [CW-1:0]       arg_col_q;
  logic [RW-1:0]       row_q;
  logic [CW-1:0]       col_q;
  logic [AW-1:0]       lin_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       cell_q;
  logic [TW-1:0]       cnt_q;
  logic                scrolled_q;
  logic [7:0]          rd_char_q;
  logic [7:0]          rd_attr_q;
  logic [7:0]          attr_q;
  logic                m_valid_q;
  logic [tccs_pkg::OUT_DATA_W-1:0] m_data_q;

  logic [15:0]         mem_q [CELLS];
  logic [15:0]         rdata_q;
  logic                we;
  logic [AW-1:0]       wa;
  logic [AW-1:0]       ra;
  logic [15:0]         wd;

  logic [7:0]          in_char;
  logic [6:0]          in_col;
  logic [4:0]          in_row;
  logic [RW-1:0]       sat_row;
  logic [CW-1:0]       sat_col;
  logic [AW-1:0]       cell_lin;
  logic                is_put_plain;
  logic                mod_start;
  logic                mod_done;
  logic [TW-1:0]       mod_rem;
  logic                at_row_end;
  logic                at_last_row;
  logic                out_push;

  assign in_char = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[14:8];
  assign in_row  = s_axis_tdata[19:15];

  // out-of-range positions clamp to the last row and column
  assign sat_row = (32'(in_row) >= 32'(ROWS))    ? RW'(ROWS - 1)    : RW'(in_row);
  assign sat_col = (32'(in_col) >= 32'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(in_col);

  assign cell_lin = AW'(arg_row_q) * AW'(COLUMNS) + AW'(arg_col_q);

  assign is_put_plain = (cmd_q == tccs_pkg::CMD_PUT) && (char_q != tccs_pkg::CH_NEWLINE)
                        && (char_q != tccs_pkg::CH_TAB);
  assign mod_start    = (state_q == S_DECODE) && (cmd_q == tccs_pkg::CMD_PUT)
                        && (char_q == tccs_pkg::CH_TAB);
  assign at_row_end   = (col_q == CW'(COLUMNS - 1));
  assign at_last_row  = (row_q == RW'(ROWS - 1));
  assign out_push     = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  tccs_mod_unit #(
    .LIN_W    (AW),
    .TAB_STOP (TAB_STOP)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lin_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // screen ram port selection
  always_comb begin
    we = 1'b0;
    wa = addr_q;
    wd = {attr_q, tccs_pkg::CH_SPACE};
    ra = cell_q;
    unique case (state_q)
      S_DECODE: begin
        if (is_put_plain) begin
          we = 1'b1;
          wa = lin_q;
          wd = {attr_q, char_q};
        end
      end
      S_FILL:  we = 1'b1;
      S_CP_RD: ra = AW'({1'b0, addr_q} + (AW+1)'(COLUMNS));
      S_CP_WR: begin
        we = 1'b1;
        wd = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= tccs_pkg::CMD_PUT;
      char_q     <= '0;
      arg_row_q  <= '0;
      arg_col_q  <= '0;
      row_q      <= '0;
      col_q      <= '0;
      lin_q      <= '0;
      addr_q     <= '0;
      cell_q     <= '0;
      cnt_q      <= '0;
      scrolled_q <= 1'b0;
      rd_char_q  <= '0;
      rd_attr_q  <= '0;
      attr_q     <= tccs_pkg::ATTR_RESET;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (out_push) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q      <= tccs_pkg::cmd_e'(s_axis_tuser);
            char_q     <= in_char;
            arg_row_q  <= sat_row;
            arg_col_q  <= sat_col;
            scrolled_q <= 1'b0;
            rd_char_q  <= '0;
            rd_attr_q  <= '0;
            state_q    <= S_DECODE;
          end
        end

        S_DECODE: begin
          unique case (cmd_q)
            tccs_pkg::CMD_PUT: begin
              if (char_q == tccs_pkg::CH_NEWLINE) begin
                if (at_last_row) begin
                  scrolled_q <= 1'b1;
                  row_q      <= RW'(ROWS - 1);
                  col_q      <= '0;
                  lin_q      <= AW'(CELLS - COLUMNS);
                  addr_q     <= '0;
                  state_q    <= S_CP_RD;
                end else begin
                  row_q   <= row_q + RW'(1);
                  col_q   <= '0;
                  lin_q   <= lin_q + AW'(COLUMNS) - AW'(col_q);
                  state_q <= S_DONE;
                end
              end else if (char_q == tccs_pkg::CH_TAB) begin
                state_q <= S_TAB_REM;
              end else begin
                // cell written this cycle, then one step forward
                cnt_q   <= TW'(1);
                state_q <= S_STEP;
              end
            end
            tccs_pkg::CMD_SET: begin
              row_q   <= arg_row_q;
              col_q   <= arg_col_q;
              lin_q   <= cell_lin;
              state_q <= S_DONE;
            end
            tccs_pkg::CMD_CLEAR: begin
              row_q   <= '0;
              col_q   <= '0;
              lin_q   <= '0;
              addr_q  <= '0;
              state_q <= S_FILL;
            end
            tccs_pkg::CMD_READ: begin
              cell_q  <= cell_lin;
              state_q <= S_RD;
            end
            default: state_q <= S_DONE;
          endcase
        end

        S_TAB_REM: begin
          if (mod_done) begin
            cnt_q   <= TW'(TAB_STOP) - mod_rem;
            state_q <= S_STEP;
          end
        end

        // advance one cell a cycle; passing the last cell scrolls at once
        S_STEP: begin
          if (at_row_end && at_last_row) begin
            scrolled_q <= 1'b1;
            row_q      <= RW'(ROWS - 1);
            col_q      <= '0;
            lin_q      <= AW'(CELLS - COLUMNS);
            addr_q     <= '0;
            state_q    <= S_CP_RD;
          end else begin
            if (at_row_end) begin
              col_q <= '0;
              row_q <= row_q + RW'(1);
            end else begin
              col_q <= col_q + CW'(1);
            end
            lin_q <= lin_q + AW'(1);
            cnt_q <= cnt_q - TW'(1);
            if (cnt_q == TW'(1)) begin
              state_q <= S_DONE;
            end
          end
        end

        S_CP_RD: state_q <= S_CP_WR;

        S_CP_WR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == AW'(CELLS - COLUMNS - 1)) begin
            state_q <= S_FILL;
          end else begin
            state_q <= S_CP_RD;
          end
        end

        S_FILL: begin
          if (addr_q == AW'(CELLS - 1)) begin
            state_q <= S_DONE;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end

        S_RD: state_q <= S_RDW;

        S_RDW: begin
          rd_char_q <= rdata_q[7:0];
          rd_attr_q <= rdata_q[15:8];
          state_q   <= S_DONE;
        end

        S_DONE: begin
          if (out_push) begin
            m_data_q  <= {3'b000, scrolled_q, rd_attr_q, rd_char_q, 5'(row_q), 7'(col_q)};
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for text_console_cursor_scroll_unit, with a cycle-free
// console predictor (screen store, cursor, attribute) checked against every result
// depends on tccs_pkg and text_console_cursor_scroll_unit only

module tb_top;

  localparam int unsigned COLS  = tccs_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS  = tccs_pkg::ROWS_DEF;
  localparam int unsigned TAB   = tccs_pkg::TAB_STOP_DEF;
  localparam int unsigned CELLS = COLS * ROWS;
  // a scroll walks the ram twice over all but one row, plus the blank bottom row
  localparam int unsigned SCROLL_CYCLES = 2 * (ROWS - 1) * COLS + COLS + 16;
  localparam int unsigned PHASE_CMDS    = 200;
  localparam int unsigned LONG_HOLD     = 600;

  typedef struct packed {
    tccs_pkg::cmd_e op;
    logic [7:0]     ch;
    logic [6:0]     col;
    logic [4:0]     row;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } cursor_report_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [tccs_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic [tccs_pkg::IN_USER_W-1:0]    s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [tccs_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [7:0]                        cfg_data_i = '0;

  // predicted console state
  logic [15:0]  screen_mem [CELLS];
  int unsigned  cursor_lin = 0;
  logic [7:0]   text_attr = tccs_pkg::ATTR_RESET;

  console_cmd_t   pending_cmds[$];
  cursor_report_t expected_reports[$];

  int unsigned mismatch_count = 0;
  int unsigned reports_seen = 0;
  bit          cmd_taken = 1'b0;
  bit          idling_ok = 1'b1;
  bit          src_idle_mode = 1'b1;
  bit          sink_idle_mode = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold_left = 0;
  bit          sink_hold_done = 1'b0;

  text_console_cursor_scroll_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic cursor_report_t console_apply(input console_cmd_t c);
    cursor_report_t rep;
    int unsigned    r;
    int unsigned    cl;
    int unsigned    k;
    rep = '0;
    r  = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
    cl = (c.col > COLS - 1) ? COLS - 1 : c.col;
    case (c.op)
      tccs_pkg::CMD_PUT: begin
        if (c.ch == tccs_pkg::CH_NEWLINE) begin
          cursor_lin += COLS - cursor_lin % COLS;
        end else if (c.ch == tccs_pkg::CH_TAB) begin
          cursor_lin += TAB - cursor_lin % TAB;
        end else begin
          if (cursor_lin < CELLS) screen_mem[cursor_lin] = {text_attr, c.ch};
          cursor_lin++;
        end
        if (cursor_lin >= CELLS) begin
          for (k = 0; k < CELLS - COLS; k++) screen_mem[k] = screen_mem[k + COLS];
          for (k = CELLS - COLS; k < CELLS; k++) screen_mem[k] = {text_attr, tccs_pkg::CH_SPACE};
          cursor_lin   = CELLS - COLS;
          rep.scrolled = 1'b1;
        end
      end
      tccs_pkg::CMD_SET: begin
        cursor_lin = r * COLS + cl;
      end
      tccs_pkg::CMD_CLEAR: begin
        for (k = 0; k < CELLS; k++) screen_mem[k] = {text_attr, tccs_pkg::CH_SPACE};
        cursor_lin = 0;
      end
      default: begin
        rep.cell_char = screen_mem[r * COLS + cl][7:0];
        rep.cell_attr = screen_mem[r * COLS + cl][15:8];
      end
    endcase
    rep.cur_col = 7'(cursor_lin % COLS);
    rep.cur_row = 5'(cursor_lin / COLS);
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on report %0d, %s: got %0d, expected %0d", reports_seen, what, got, want);
    mismatch_count++;
  endtask

  // input and output handshakes, output side first so a same-edge push is never consumed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        if (m_axis_tdata[6:0] != expected_reports[0].cur_col)
          report_mismatch("cursor_col", m_axis_tdata[6:0], expected_reports[0].cur_col);
        if (m_axis_tdata[11:7] != expected_reports[0].cur_row)
          report_mismatch("cursor_row", m_axis_tdata[11:7], expected_reports[0].cur_row);
        if (m_axis_tdata[19:12] != expected_reports[0].cell_char)
          report_mismatch("cell_char", m_axis_tdata[19:12], expected_reports[0].cell_char);
        if (m_axis_tdata[27:20] != expected_reports[0].cell_attr)
          report_mismatch("cell_attr", m_axis_tdata[27:20], expected_reports[0].cell_attr);
        if (m_axis_tdata[28] != expected_reports[0].scrolled)
          report_mismatch("scrolled", m_axis_tdata[28], expected_reports[0].scrolled);
        void'(expected_reports.pop_front());
      end
      reports_seen++;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_reports.push_back(console_apply(pending_cmds[0]));
      cmd_taken = 1'b1;
    end
  end

  // command driver: holds the front command until taken, idles in bursts
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !cmd_taken)) begin
      if (s_axis_tvalid) begin
        void'(pending_cmds.pop_front());
        cmd_taken = 1'b0;
        if ($urandom_range(0, 63) == 0) src_idle_mode = !src_idle_mode;
        if (idling_ok && src_idle_mode && $urandom_range(0, 5) == 0)
          src_gap = $urandom_range(1, 12);
      end
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pending_cmds[0].row, pending_cmds[0].col, pending_cmds[0].ch};
        s_axis_tuser  <= pending_cmds[0].op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: random stalls, plus one long hold while commands keep coming
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!sink_hold_done && reports_seen >= 400 && s_axis_tvalid) begin
      sink_hold_done = 1'b1;
      sink_hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) sink_idle_mode = !sink_idle_mode;
      if (idling_ok && sink_idle_mode && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(input tccs_pkg::cmd_e op, input logic [7:0] ch,
                          input logic [6:0] col, input logic [4:0] row);
    console_cmd_t c;
    c.op  = op;
    c.ch  = ch;
    c.col = col;
    c.row = row;
    pending_cmds.push_back(c);
  endtask

  // mostly text with cursor moves near the bottom, so writes, reads and scrolls meet
  task automatic queue_random_cmds(input int unsigned n);
    console_cmd_t c;
    int unsigned  pick;
    int unsigned  k;
    for (int unsigned i = 0; i < n; i++) begin
      c.ch  = 8'($urandom);
      c.col = 7'($urandom);
      c.row = 5'($urandom);
      pick  = $urandom_range(0, 99);
      if (pick < 62) begin
        c.op = tccs_pkg::CMD_PUT;
        k = $urandom_range(0, 9);
        if (k == 0) c.ch = tccs_pkg::CH_NEWLINE;
        else if (k == 1) c.ch = tccs_pkg::CH_TAB;
        else if (k > 3) c.ch = 8'($urandom_range(33, 126));
      end else if (pick < 80) begin
        c.op = (pick < 78) ? tccs_pkg::CMD_SET : tccs_pkg::CMD_CLEAR;
      end else begin
        c.op = tccs_pkg::CMD_READ;
      end
      if (c.op == tccs_pkg::CMD_SET || c.op == tccs_pkg::CMD_READ) begin
        if ($urandom_range(0, 7) != 0) c.col = 7'($urandom_range(0, COLS - 1));
        k = $urandom_range(0, 7);
        if (k == 0) c.row = 5'($urandom);
        else if (k < 5) c.row = 5'($urandom_range(ROWS - 5, ROWS - 1));
        else c.row = 5'($urandom_range(0, ROWS - 1));
      end
      pending_cmds.push_back(c);
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    text_attr = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the screen is unknown until cleared, so a clear goes first
    push_cmd(tccs_pkg::CMD_CLEAR, 8'hFF, 7'h7F, 5'h1F);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_PUT, 8'h41, 7'h7F, 5'h1F);
    push_cmd(tccs_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_PUT, 8'hFF, 7'h55, 5'h0A);
    push_cmd(tccs_pkg::CMD_PUT, tccs_pkg::CH_TAB, 7'h2A, 5'h15);
    push_cmd(tccs_pkg::CMD_PUT, tccs_pkg::CH_NEWLINE, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd2, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd1, 5'd0);
    // out of range position saturates to the last cell
    push_cmd(tccs_pkg::CMD_SET, 8'hAA, 7'h7F, 5'h1F);
    push_cmd(tccs_pkg::CMD_READ, 8'h55, 7'h7F, 5'h1F);
    push_cmd(tccs_pkg::CMD_PUT, 8'h5A, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd79, 5'd23);
    // tab and newline on the bottom row both scroll
    push_cmd(tccs_pkg::CMD_SET, 8'h00, 7'd75, 5'd24);
    push_cmd(tccs_pkg::CMD_PUT, tccs_pkg::CH_TAB, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_SET, 8'h00, 7'd10, 5'd24);
    push_cmd(tccs_pkg::CMD_PUT, tccs_pkg::CH_NEWLINE, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd79, 5'd21);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd0, 5'd24);
    push_cmd(tccs_pkg::CMD_SET, 8'h00, 7'd79, 5'd0);
    push_cmd(tccs_pkg::CMD_PUT, 8'h7E, 7'd0, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd79, 5'd0);
    push_cmd(tccs_pkg::CMD_READ, 8'h00, 7'd0, 5'd24);
    wait_idle();

    write_attribute(8'h00);
    queue_random_cmds(PHASE_CMDS);
    wait_idle();
    write_attribute(8'hFF);
    queue_random_cmds(PHASE_CMDS);
    wait_idle();
    for (int unsigned p = 0; p < 3; p++) begin
      write_attribute(8'($urandom));
      queue_random_cmds(PHASE_CMDS);
      wait_idle();
    end
    // closing stretch runs at full rate on both sides
    idling_ok = 1'b0;
    write_attribute(8'($urandom));
    queue_random_cmds(PHASE_CMDS);
    wait_idle();

    repeat (SCROLL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** text_console_cursor_scroll_unit: PASSED **");
    end else begin
      $display("** text_console_cursor_scroll_unit: FAILED **");
    end
    $finish;
  end

  // every command a full scroll plus the longest stalls, with about ten times the margin
  initial begin
    #1_000_000_000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("** text_console_cursor_scroll_unit: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tccs_pkg.sv
rtl/tccs_mod_unit.sv
rtl/text_console_cursor_scroll_unit.sv
verif/tb_top.sv
